>>> hw/rtl/sfr_pkg.sv
// Shared types and constants for the stuffed frame receiver.
// Used by every module under hw/rtl; depends on nothing.
package sfr_pkg;

  localparam int ERR_COUNT_WIDTH = 16;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;
  localparam logic [7:0] SEQ_CTRL  = 8'h40;
  localparam logic [7:0] RC_RR     = 8'h05;
  localparam logic [7:0] RC_REJ    = 8'h01;
  localparam logic [7:0] TYPE_DATA = 8'h01;
  localparam logic [7:0] TYPE_CTL0 = 8'h02;
  localparam logic [7:0] TYPE_CTL1 = 8'h03;

  localparam int POS_W = 17;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef enum logic [1:0] {
    EV_OPEN,
    EV_DATA,
    EV_CLOSE
  } ev_op_t;

  typedef enum logic [2:0] {
    ST_DATA_OK = 3'd0,
    ST_CTL_OK  = 3'd1,
    ST_HDR_ERR = 3'd2,
    ST_SEQ_ERR = 3'd3,
    ST_CHK_ERR = 3'd4,
    ST_UNKNOWN = 3'd5
  } status_t;

  // One classified line event handed from front to back.
  typedef struct packed {
    ev_op_t     op;
    logic [7:0] data;
    logic       tentative;  // forward the held byte first
    logic       absorb;     // data (or a literal escape on close) enters the frame
  } event_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic        reply_valid;
    logic [7:0]  reply_control;
    logic [15:0] data_length;
    logic [15:0] error_total;
  } result_t;

endpackage

>>> hw/rtl/stuffed_frame_receiver.sv
// Byte-stuffed frame receiver: flag hunt, destuffing, header/sequence/data checks.
// An accepted line byte is registered in the event queue; any result it yields is registered in the result queue.
// Throughput: one line byte per cycle; full rises only when the two-entry event
// queue is full, which happens when the two-entry result queue is not being popped.
// Reset (rst_n low, synchronous) hunts for a flag with sequence bit and error count cleared.
// Instantiates sfr_front, sfr_evq and sfr_back; depends on sfr_pkg.
module stuffed_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic        out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [2:0]  out_status,
  output logic        out_reply_valid,
  output logic [7:0]  out_reply_control,
  output logic [15:0] out_data_length,
  output logic [15:0] out_error_total
);
  import sfr_pkg::*;

  event_t  fe_ev, q_ev;
  logic    fe_push, q_full, q_valid, q_pop;
  result_t res;

  sfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_rx_byte (in_rx_byte),
    .ev_full    (q_full),
    .full       (full),
    .ev_push    (fe_push),
    .ev         (fe_ev)
  );

  sfr_evq u_evq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (fe_push),
    .wr_ev    (fe_ev),
    .q_full   (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_ev    (q_ev)
  );

  sfr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .ev_valid (q_valid),
    .ev       (q_ev),
    .ev_pop   (q_pop),
    .empty    (empty),
    .pop      (pop),
    .res      (res)
  );

  assign out_kind          = res.kind;
  assign out_payload_byte  = res.payload_byte;
  assign out_status        = res.status;
  assign out_reply_valid   = res.reply_valid;
  assign out_reply_control = res.reply_control;
  assign out_data_length   = res.data_length;
  assign out_error_total   = res.error_total;

endmodule

>>> hw/rtl/sfr_front.sv
// Front end: flag hunt and escape removal, one line byte per cycle while the event queue is not full.
// Emits classified events; depends on sfr_pkg.
module sfr_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  logic [7:0]      in_rx_byte,
  input  logic            ev_full,
  output logic            full,
  output logic            ev_push,
  output sfr_pkg::event_t ev
);
  import sfr_pkg::*;

  logic in_frame_r, in_frame_nxt;
  logic esc_r, esc_nxt;
  logic accept;

  assign full   = ev_full;
  assign accept = push && !ev_full;

  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    ev_push      = 1'b0;
    ev.op        = EV_DATA;
    ev.data      = in_rx_byte;
    ev.tentative = 1'b0;
    ev.absorb    = 1'b0;
    if (accept) begin
      priority if (!in_frame_r) begin
        if (in_rx_byte == FLAG_BYTE) begin
          ev_push      = 1'b1;
          ev.op        = EV_OPEN;
          in_frame_nxt = 1'b1;
          esc_nxt      = 1'b0;
        end
      end else if (in_rx_byte == FLAG_BYTE) begin
        ev_push      = 1'b1;
        ev.op        = EV_CLOSE;
        ev.absorb    = esc_r;
        in_frame_nxt = 1'b0;
        esc_nxt      = 1'b0;
      end else if (esc_r) begin
        ev_push   = 1'b1;
        ev.data   = in_rx_byte ^ ESC_XOR;
        ev.absorb = 1'b1;
        esc_nxt   = 1'b0;
      end else begin
        ev_push      = 1'b1;
        ev.tentative = 1'b1;
        ev.absorb    = (in_rx_byte != ESC_BYTE);
        esc_nxt      = (in_rx_byte == ESC_BYTE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
    end
  end

endmodule

>>> hw/rtl/sfr_evq.sv
// Two-entry event queue between front and back end.
// Depends on sfr_pkg.
module sfr_evq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  sfr_pkg::event_t wr_ev,
  output logic            q_full,
  input  logic            rd_en,
  output logic            rd_valid,
  output sfr_pkg::event_t rd_ev
);
  import sfr_pkg::*;

  event_t     mem [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_wr, do_rd;

  assign q_full   = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_ev    = mem[rp_r];
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wp_nxt  = wp_r ^ do_wr;
    rp_nxt  = rp_r ^ do_rd;
    cnt_nxt = cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp_r] <= wr_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("event queue overfilled");
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wp_r == rp_r))
    else $error("event queue pointers out of step");

endmodule

>>> hw/rtl/sfr_back.sv
// Back end: frame field capture, check byte, verdict and result queue.
// Consumes events from sfr_evq; depends on sfr_pkg.
module sfr_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             ev_valid,
  input  sfr_pkg::event_t  ev,
  output logic             ev_pop,
  output logic             empty,
  input  logic             pop,
  output sfr_pkg::result_t res
);
  import sfr_pkg::*;

  logic [POS_W-1:0]           pos_r, pos_nxt;
  logic [7:0]                 addr_r, addr_nxt;
  logic [7:0]                 ctrl_r, ctrl_nxt;
  logic                       hdr_r, hdr_nxt;
  logic [7:0]                 type_r, type_nxt;
  logic [15:0]                len_r, len_nxt;
  logic [7:0]                 xor_r, xor_nxt;
  logic [7:0]                 held_r, held_nxt;
  logic                       seq_r, seq_nxt;
  logic [ERR_COUNT_WIDTH-1:0] err_r, err_nxt;

  result_t    oq [2];
  logic       owp_r, orp_r;
  logic [1:0] ocnt_r, ocnt_nxt;
  logic       adv, res_push, do_pop;
  result_t    res_new;

  logic [7:0] ab;
  logic       ab_en;
  logic [7:0] sb;

  assign adv    = ev_valid && (ocnt_r != 2'd2);
  assign ev_pop = adv;
  assign empty  = (ocnt_r == 2'd0);
  assign res    = oq[orp_r];
  assign do_pop = pop && !empty;
  assign sb     = {seq_r, 7'd0};

  // byte entering the frame this cycle
  always_comb begin
    ab    = (ev.op == EV_CLOSE) ? ESC_BYTE : ev.data;
    ab_en = adv && (ev.op != EV_OPEN) && ev.absorb;
  end

  always_comb begin
    pos_nxt  = pos_r;
    addr_nxt = addr_r;
    ctrl_nxt = ctrl_r;
    hdr_nxt  = hdr_r;
    type_nxt = type_r;
    len_nxt  = len_r;
    xor_nxt  = xor_r;
    held_nxt = held_r;
    if (adv && ev.op == EV_OPEN) begin
      pos_nxt  = POS_W'(1);
      addr_nxt = '0;
      ctrl_nxt = '0;
      hdr_nxt  = 1'b0;
      type_nxt = '0;
      len_nxt  = '0;
      xor_nxt  = '0;
      held_nxt = '0;
    end else if (ab_en) begin
      unique case (pos_r)
        POS_W'(1): addr_nxt = ab;
        POS_W'(2): ctrl_nxt = ab;
        POS_W'(3): hdr_nxt  = ((addr_r ^ ctrl_r) == ab);
        POS_W'(4): type_nxt = ab;
        POS_W'(6): len_nxt  = {ab, len_r[7:0]};
        POS_W'(7): len_nxt  = {len_r[15:8], ab};
        default: ;
      endcase
      if (pos_r >= POS_W'(4)) begin
        if (pos_r < POS_W'(8) || (pos_r - POS_W'(8)) < {1'b0, len_r}) begin
          xor_nxt = xor_r ^ ab;
        end
        held_nxt = ab;
      end
      if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  // forwarded held bytes, and the verdict on the frame as it stands after any literal escape
  always_comb begin
    seq_nxt  = seq_r;
    err_nxt  = err_r;
    res_push = 1'b0;
    res_new  = '0;
    if (adv && ev.op == EV_DATA && ev.tentative && pos_r >= POS_W'(5)) begin
      res_push             = 1'b1;
      res_new.payload_byte = held_r;
      res_new.error_total  = 16'(err_r);
    end else if (adv && ev.op == EV_CLOSE) begin
      res_push            = 1'b1;
      res_new.kind        = 1'b1;
      res_new.reply_valid = 1'b1;
      res_new.data_length = len_nxt;
      priority if (!hdr_nxt) begin
        res_new.status        = ST_HDR_ERR;
        res_new.reply_control = sb | RC_REJ;
      end else if ((ctrl_nxt ^ {1'b0, seq_r, 6'd0}) != SEQ_CTRL) begin
        res_new.status        = ST_SEQ_ERR;
        res_new.reply_control = sb | RC_RR;
      end else if (type_nxt == TYPE_DATA) begin
        if (xor_nxt == held_nxt) begin
          res_new.status        = ST_DATA_OK;
          res_new.reply_control = sb | RC_RR;
          seq_nxt               = !seq_r;
        end else begin
          res_new.status        = ST_CHK_ERR;
          res_new.reply_control = sb | RC_REJ;
          if (err_r != '1) begin
            err_nxt = err_r + ERR_COUNT_WIDTH'(1);
          end
        end
      end else if (type_nxt == TYPE_CTL0 || type_nxt == TYPE_CTL1) begin
        res_new.status        = ST_CTL_OK;
        res_new.reply_control = sb | RC_RR;
        seq_nxt               = !seq_r;
      end else begin
        res_new.status      = ST_UNKNOWN;
        res_new.reply_valid = 1'b0;
      end
      res_new.error_total = 16'(err_nxt);
    end
  end

  assign ocnt_nxt = ocnt_r + {1'b0, res_push} - {1'b0, do_pop};

  always_ff @(posedge clk) begin
    if (res_push) begin
      oq[owp_r] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      addr_r <= '0;
      ctrl_r <= '0;
      hdr_r  <= 1'b0;
      type_r <= '0;
      len_r  <= '0;
      xor_r  <= '0;
      held_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      addr_r <= addr_nxt;
      ctrl_r <= ctrl_nxt;
      hdr_r  <= hdr_nxt;
      type_r <= type_nxt;
      len_r  <= len_nxt;
      xor_r  <= xor_nxt;
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= 1'b0;
      err_r  <= '0;
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      seq_r  <= seq_nxt;
      err_r  <= err_nxt;
      owp_r  <= owp_r ^ res_push;
      orp_r  <= orp_r ^ do_pop;
      ocnt_r <= ocnt_nxt;
    end
  end

  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= 2'd2) else $error("result queue overfilled");
  a_seq_on_close: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && seq_r != $past(seq_r)) |->
      ($past(adv) && $past(ev.op) == EV_CLOSE))
    else $error("sequence bit moved outside a verdict");
  a_err_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (err_r >= $past(err_r)))
    else $error("error count went down");
  a_err_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && err_r != $past(err_r)) |->
      ($past(res_new.status) == ST_CHK_ERR && $past(res_push)))
    else $error("error count moved without a data check error");

endmodule

>>> bench/sfr_result_checker.sv
// Result checker for the stuffed frame receiver: watches both request channels,
// predicts each frame's tentative bytes and verdicts, and compares them in order.
// Depends on sfr_pkg for the result layout, status codes and protocol constants.
module sfr_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  in_rx_byte,
  input  logic        empty,
  input  logic        pop,
  input  logic        out_kind,
  input  logic [7:0]  out_payload_byte,
  input  logic [2:0]  out_status,
  input  logic        out_reply_valid,
  input  logic [7:0]  out_reply_control,
  input  logic [15:0] out_data_length,
  input  logic [15:0] out_error_total,
  output int          fail_count,
  output int          pending
);
  import sfr_pkg::*;

  logic                       in_frame;
  logic                       esc_pend;
  logic [POS_W-1:0]           pos;
  logic [7:0]                 addr_b;
  logic [7:0]                 ctrl_b;
  logic                       hdr_ok;
  logic [7:0]                 ptype;
  logic [15:0]                len_f;
  logic [7:0]                 chk_xor;
  logic [7:0]                 held;
  logic                       seq_bit;
  logic [ERR_COUNT_WIDTH-1:0] err_cnt;
  result_t                    frame_results[$];

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  task automatic clear_frame();
    esc_pend = 1'b0;
    pos      = 1;
    addr_b   = '0;
    ctrl_b   = '0;
    hdr_ok   = 1'b0;
    ptype    = '0;
    len_f    = '0;
    chk_xor  = '0;
    held     = '0;
  endtask

  task automatic add_result(input logic kind, input logic [7:0] pay, input status_t st,
                            input logic rv, input logic [7:0] rc, input logic [15:0] len);
    result_t r;
    r.kind          = kind;
    r.payload_byte  = pay;
    r.status        = st;
    r.reply_valid   = rv;
    r.reply_control = rc;
    r.data_length   = len;
    r.error_total   = 16'(err_cnt);
    frame_results.push_back(r);
  endtask

  // one destuffed byte enters the frame
  task automatic take_byte(input logic [7:0] b);
    if (pos == 1) addr_b = b;
    else if (pos == 2) ctrl_b = b;
    else if (pos == 3) hdr_ok = ((addr_b ^ ctrl_b) == b);
    else if (pos == 4) ptype = b;
    else if (pos == 6) len_f = {b, 8'h00};
    else if (pos == 7) len_f[7:0] = b;
    if (pos >= 4) begin
      if (pos < 8 || (pos - 8) < len_f) chk_xor ^= b;
      held = b;
    end
    if (pos != POS_MAX) pos++;
  endtask

  task automatic predict_byte(input logic [7:0] b);
    logic [7:0] sb;
    logic [7:0] rc;
    logic       rv;
    status_t    st;
    if (!in_frame) begin
      if (b == FLAG_BYTE) begin
        clear_frame();
        in_frame = 1'b1;
      end
    end else if (b == FLAG_BYTE) begin
      // escape right before the flag is a literal byte
      if (esc_pend) begin
        esc_pend = 1'b0;
        take_byte(ESC_BYTE);
      end
      in_frame = 1'b0;
      sb = seq_bit ? 8'h80 : 8'h00;
      rv = 1'b1;
      if (!hdr_ok) begin
        st = ST_HDR_ERR;
        rc = sb | RC_REJ;
      end else if (ctrl_b != (SEQ_CTRL ^ (seq_bit ? SEQ_CTRL : 8'h00))) begin
        st = ST_SEQ_ERR;
        rc = sb | RC_RR;
      end else if (ptype == TYPE_DATA) begin
        if (chk_xor == held) begin
          st      = ST_DATA_OK;
          rc      = sb | RC_RR;
          seq_bit = ~seq_bit;
        end else begin
          st = ST_CHK_ERR;
          rc = sb | RC_REJ;
          if (err_cnt != '1) err_cnt++;
        end
      end else if (ptype == TYPE_CTL0 || ptype == TYPE_CTL1) begin
        st      = ST_CTL_OK;
        rc      = sb | RC_RR;
        seq_bit = ~seq_bit;
      end else begin
        st = ST_UNKNOWN;
        rv = 1'b0;
        rc = 8'h00;
      end
      add_result(1'b1, 8'h00, st, rv, rc, len_f);
    end else if (esc_pend) begin
      esc_pend = 1'b0;
      take_byte(b ^ ESC_XOR);
    end else begin
      if (pos >= 5) add_result(1'b0, held, ST_DATA_OK, 1'b0, 8'h00, 16'h0000);
      if (b == ESC_BYTE) esc_pend = 1'b1;
      else take_byte(b);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      clear_frame();
      pos      = '0;
      in_frame = 1'b0;
      seq_bit  = 1'b0;
      err_cnt  = '0;
      frame_results.delete();
    end else begin
      if (pop && !empty) begin
        if (frame_results.size() == 0) begin
          report_mismatch("result popped with nothing expected");
        end else begin
          want = frame_results.pop_front();
          check_field("kind", 16'(out_kind), 16'(want.kind));
          check_field("payload_byte", 16'(out_payload_byte), 16'(want.payload_byte));
          check_field("status", 16'(out_status), 16'(want.status));
          check_field("reply_valid", 16'(out_reply_valid), 16'(want.reply_valid));
          check_field("reply_control", 16'(out_reply_control), 16'(want.reply_control));
          check_field("data_length", out_data_length, want.data_length);
          check_field("error_total", out_error_total, want.error_total);
        end
      end
      if (push && !full) predict_byte(in_rx_byte);
    end
    pending = frame_results.size();
  end

endmodule

>>> bench/tb_stuffed_frame_receiver.sv
// Top of the stuffed frame receiver bench: clock, reset, line-byte requests built
// from stuffed frames, result pops with random idling, and the final verdict.
// Depends on sfr_pkg, stuffed_frame_receiver and sfr_result_checker.
module tb_stuffed_frame_receiver;
  import sfr_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_rx_byte;
  logic        empty;
  logic        pop;
  logic        out_kind;
  logic [7:0]  out_payload_byte;
  logic [2:0]  out_status;
  logic        out_reply_valid;
  logic [7:0]  out_reply_control;
  logic [15:0] out_data_length;
  logic [15:0] out_error_total;

  int          fail_count;
  int          pending;
  int          send_idle;
  int          recv_idle;
  bit          hold_req;
  int          frame_bytes;
  logic [7:0]  line_q[$];

  stuffed_frame_receiver DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_rx_byte        (in_rx_byte),
    .empty             (empty),
    .pop               (pop),
    .out_kind          (out_kind),
    .out_payload_byte  (out_payload_byte),
    .out_status        (out_status),
    .out_reply_valid   (out_reply_valid),
    .out_reply_control (out_reply_control),
    .out_data_length   (out_data_length),
    .out_error_total   (out_error_total)
  );

  sfr_result_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_rx_byte        (in_rx_byte),
    .empty             (empty),
    .pop               (pop),
    .out_kind          (out_kind),
    .out_payload_byte  (out_payload_byte),
    .out_status        (out_status),
    .out_reply_valid   (out_reply_valid),
    .out_reply_control (out_reply_control),
    .out_data_length   (out_data_length),
    .out_error_total   (out_error_total),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 400000);
    $display("** stuffed_frame_receiver: FAILED **");
    $finish;
  end

  // result side: random pops, plus a long hold-off on request
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (80) @(negedge clk);
      end
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  // called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      in_rx_byte <= 8'($urandom_range(255));
      @(negedge clk);
    end
    push <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    push <= 1'b0;
    wait (pending == 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic put_stuffed(input logic [7:0] b);
    if (b == FLAG_BYTE || b == ESC_BYTE || $urandom_range(19) == 0) begin
      line_q.push_back(ESC_BYTE);
      line_q.push_back(b ^ ESC_XOR);
    end else begin
      line_q.push_back(b);
    end
  endtask

  // noise, then a mostly well-formed frame with random content and faults
  task automatic build_frame(output int n_noise);
    logic [7:0]  a;
    logic [7:0]  c;
    logic [7:0]  bcc;
    logic [7:0]  kind_b;
    logic [7:0]  x;
    logic [7:0]  d;
    logic [15:0] len;
    logic [7:0]  body[$];
    int          ndata;
    int          r;
    line_q = {};
    n_noise = $urandom_range(0, 2);
    repeat (n_noise) begin
      d = 8'($urandom_range(255));
      line_q.push_back((d == FLAG_BYTE) ? 8'h7F : d);
    end
    line_q.push_back(FLAG_BYTE);
    a = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'h03;
    c = $urandom_range(1) ? SEQ_CTRL : 8'h00;
    if ($urandom_range(9) == 0) c = 8'($urandom_range(255));
    bcc = a ^ c;
    if ($urandom_range(11) == 0) bcc ^= 8'($urandom_range(1, 255));
    r = $urandom_range(9);
    kind_b = (r == 6) ? TYPE_CTL0 : (r == 7) ? TYPE_CTL1 :
             (r == 8) ? 8'($urandom_range(255)) : TYPE_DATA;
    if ($urandom_range(14) == 0) len = 16'($urandom_range(65535));
    else len = 16'($urandom_range(0, 10));
    ndata = (len > 10) ? $urandom_range(0, 6) : int'(len);
    if ($urandom_range(9) == 0) ndata = $urandom_range(0, 12);
    body = '{a, c, bcc, kind_b, 8'($urandom_range(255)), len[15:8], len[7:0]};
    x = kind_b ^ body[4] ^ len[15:8] ^ len[7:0];
    repeat (ndata) begin
      if ($urandom_range(3) == 0) d = $urandom_range(1) ? FLAG_BYTE : ESC_BYTE;
      else d = 8'($urandom_range(255));
      body.push_back(d);
      x ^= d;
    end
    if ($urandom_range(9) == 0) x ^= 8'($urandom_range(1, 255));
    body.push_back(x);
    // short frame
    if ($urandom_range(11) == 0)
      while (body.size() > $urandom_range(0, 7)) void'(body.pop_back());
    foreach (body[i]) begin
      // raw double escape ahead of the check byte
      if (i == body.size() - 1 && $urandom_range(14) == 0) begin
        line_q.push_back(ESC_BYTE);
        line_q.push_back(ESC_BYTE);
      end
      put_stuffed(body[i]);
    end
    if ($urandom_range(11) == 0) line_q.push_back(ESC_BYTE);
    line_q.push_back(FLAG_BYTE);
  endtask

  task automatic run_phase(input int s_idle, input int r_idle, input int n_items,
                           input bit with_hold);
    int goal;
    int n_noise;
    send_idle = s_idle;
    recv_idle = r_idle;
    goal = frame_bytes + n_items;
    if (with_hold) hold_req = 1'b1;
    while (frame_bytes < goal) begin
      build_frame(n_noise);
      foreach (line_q[i]) send_byte(line_q[i]);
      frame_bytes += line_q.size() - n_noise;
      if (with_hold && $urandom_range(29) == 0) hold_req = 1'b1;
    end
    settle();
  endtask

  initial begin
    logic [7:0] directed[] = '{8'h00, 8'hFF,
                               8'h7E, 8'h03, 8'h40, 8'h43, 8'h02, 8'h7E,
                               8'h7E, 8'h7E,
                               8'h7E, 8'h01, 8'h00, 8'h01, 8'h01,
                               8'h7D, 8'h7D, 8'h7D, 8'h7E,
                               8'h7E, 8'h03, 8'h00, 8'h03, 8'h01,
                               8'h00, 8'h00, 8'h00, 8'h01, 8'h7E};
    rst_n       = 1'b0;
    push        = 1'b0;
    in_rx_byte  = 8'h00;
    send_idle   = 0;
    recv_idle   = 0;
    hold_req    = 1'b0;
    frame_bytes = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_byte(directed[i]);
    settle();

    run_phase(31, 76, 500, 1'b0);
    run_phase(76, 31, 500, 1'b0);
    run_phase(0, 0, 500, 1'b1);

    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("** stuffed_frame_receiver: PASSED **");
    else $display("** stuffed_frame_receiver: FAILED **");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_front.sv
hw/rtl/sfr_evq.sv
hw/rtl/sfr_back.sv
hw/rtl/stuffed_frame_receiver.sv
bench/sfr_result_checker.sv
bench/tb_stuffed_frame_receiver.sv
